[src/arp_pkg.sv]
// shared constants for the auto-ranging sample plot scaler
package arp_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int SCALE_MAX  = 4095;

  localparam int FRAME_POINTS_DEF = 91;
  localparam int PLOT_HEIGHT_DEF  = 140;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL = 2'd2;

  localparam logic                AUTO_RST  = 1'b1;
  localparam logic [SAMPLE_W-1:0] STEP_RST  = 12'd20;
  localparam logic [SAMPLE_W-1:0] SCALE_RST = 12'd100;

endpackage

[src/arp_div.sv]
// restoring divider, one quotient bit per cycle
module arp_div #(
  parameter int NW = 20,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CNT_W = $clog2(NW + 1);

  logic          busy;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0] a_sh;
  logic [DW-1:0] b_reg;
  logic [DW-1:0] r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {r, a_sh[NW-1]};
  assign ge    = trial >= {1'b0, b_reg};
  assign diff  = trial - {1'b0, b_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= dividend;
      b_reg <= divisor;
      r     <= '0;
    end else if (busy) begin
      a_sh <= {a_sh[NW-2:0], ge};
      r    <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quotient  = a_sh;
  assign remainder = r;

endmodule

[src/auto_ranging_sample_plot_scaler.sv]
// auto-ranging sample plot scaler: top level with sequencer and state
// each item runs one division for its height; a frame-opening item with auto-ranging on
// runs four divisions (average, its rounding to the step, peak rounding, height)
// a new sample is taken only after the previous item has moved to the output register
// all work runs through one shared bit-serial divider
// synchronous reset: full scale 100, step 20, auto-ranging on, statistics cleared
module auto_ranging_sample_plot_scaler #(
  parameter int FRAME_POINTS = arp_pkg::FRAME_POINTS_DEF,
  parameter int PLOT_HEIGHT  = arp_pkg::PLOT_HEIGHT_DEF,
  localparam int CW = $clog2(FRAME_POINTS),
  localparam int HW = $clog2(PLOT_HEIGHT + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [arp_pkg::SAMPLE_W-1:0]   sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [CW-1:0]                  column,
  output logic [HW-1:0]                  plot_height,
  output logic                           frame_start,
  output logic [arp_pkg::SAMPLE_W-1:0]   full_scale,
  input  logic                           cfg_write,
  input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import arp_pkg::*;

  localparam int SW  = $clog2((FRAME_POINTS + 1) * SCALE_MAX + 1);
  localparam int PW  = $clog2(PLOT_HEIGHT * SCALE_MAX + 1);
  localparam int NW0 = SW > PW ? SW : PW;
  localparam int NW  = NW0 > SAMPLE_W + 1 ? NW0 : SAMPLE_W + 1;
  localparam int FW  = $clog2(FRAME_POINTS + 1);
  localparam int DW  = FW > SAMPLE_W ? FW : SAMPLE_W;

  localparam logic [DW-1:0] FP_D     = DW'(FRAME_POINTS);
  localparam logic [NW-1:0] PH_N     = NW'(PLOT_HEIGHT);
  localparam logic [HW-1:0] PH_H     = HW'(PLOT_HEIGHT);
  localparam logic [CW-1:0] LAST_COL = CW'(FRAME_POINTS - 1);
  localparam logic [NW-1:0] HALF_LIM = NW'(SCALE_MAX / 2);
  localparam logic [SAMPLE_W-1:0] LIM = SAMPLE_W'(SCALE_MAX);
  localparam logic [SAMPLE_W-1:0] ONE = SAMPLE_W'(1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SETUP   = 3'd1;
  localparam logic [2:0] ST_AVG     = 3'd2;
  localparam logic [2:0] ST_AVG_RND = 3'd3;
  localparam logic [2:0] ST_PK_RND  = 3'd4;
  localparam logic [2:0] ST_HEIGHT  = 3'd5;
  localparam logic [2:0] ST_OUT     = 3'd6;

  logic [2:0]          state;
  logic                auto_en;
  logic [SAMPLE_W-1:0] step;
  logic [CW-1:0]       column_count;
  logic                first_done;
  logic [SW-1:0]       run_sum;
  logic [SAMPLE_W-1:0] run_peak;
  logic [SAMPLE_W-1:0] cur_scale;
  logic                start_r;

  logic [SAMPLE_W-1:0] smp;
  logic [CW-1:0]       col_r;
  logic [SAMPLE_W-1:0] rnd_avg;
  logic [HW-1:0]       hgt;

  logic                div_start;
  logic [NW-1:0]       div_a;
  logic [DW-1:0]       div_b;
  logic                div_done;
  logic [NW-1:0]       div_q;
  logic [DW-1:0]       div_r;

  logic                accept;
  logic                out_free;
  logic [SAMPLE_W-1:0] step_eff;
  logic [SAMPLE_W-1:0] peak_new;
  logic [SAMPLE_W-1:0] avg_v;
  logic [SAMPLE_W+1:0] pk3;
  logic [SAMPLE_W-1:0] pk_v;
  logic [SAMPLE_W-1:0] rnd_cur;
  logic [SAMPLE_W-1:0] fs_max;
  logic [SAMPLE_W-1:0] fs;
  logic [NW-1:0]       prod;
  logic [HW-1:0]       h_clamp;

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign step_eff = (step == '0) ? ONE : step;
  assign peak_new = (sample > run_peak) ? sample : run_peak;

  assign avg_v   = (div_q > HALF_LIM) ? LIM : {div_q[SAMPLE_W-2:0], 1'b0};
  assign pk3     = {2'b00, run_peak} + {1'b0, run_peak, 1'b0};
  assign pk_v    = pk3[SAMPLE_W+1] ? LIM : pk3[SAMPLE_W:1];
  // rounded down to the step: operand minus remainder
  assign rnd_cur = div_a[SAMPLE_W-1:0] - div_r[SAMPLE_W-1:0];
  assign fs_max  = (rnd_avg > rnd_cur) ? rnd_avg : rnd_cur;
  assign fs      = (fs_max == '0) ? step_eff : fs_max;

  assign prod    = NW'(smp) * PH_N;
  assign h_clamp = (div_q > PH_N) ? PH_H : div_q[HW-1:0];

  arp_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  // control and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      div_start    <= 1'b0;
      auto_en      <= AUTO_RST;
      step         <= STEP_RST;
      cur_scale    <= SCALE_RST;
      column_count <= '0;
      first_done   <= 1'b0;
      run_sum      <= '0;
      run_peak     <= '0;
      start_r      <= 1'b0;
    end else begin
      div_start <= (state == ST_SETUP) ||
                   (div_done && ((state == ST_AVG) || (state == ST_AVG_RND) ||
                                 (state == ST_PK_RND)));
      if ((state == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_AUTO:   auto_en <= cfg_data[0];
          REG_STEP:   step    <= cfg_data[SAMPLE_W-1:0];
          REG_MANUAL: cur_scale <= (cfg_data[SAMPLE_W-1:0] == '0) ? ONE
                                                               : cfg_data[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            start_r    <= first_done && (column_count == '0);
            run_sum    <= run_sum + SW'(sample);
            run_peak   <= peak_new;
            first_done <= 1'b1;
            column_count <= (column_count == LAST_COL) ? '0 : column_count + 1'b1;
            state      <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (start_r && auto_en) begin
            state <= ST_AVG;
          end else begin
            if (start_r) begin
              run_sum  <= '0;
              run_peak <= '0;
            end
            state <= ST_HEIGHT;
          end
        end
        ST_AVG: begin
          if (div_done) begin
            state <= ST_AVG_RND;
          end
        end
        ST_AVG_RND: begin
          if (div_done) begin
            state <= ST_PK_RND;
          end
        end
        ST_PK_RND: begin
          if (div_done) begin
            cur_scale <= fs;
            run_sum   <= '0;
            run_peak  <= '0;
            state     <= ST_HEIGHT;
          end
        end
        ST_HEIGHT: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // operands, intermediate results and output item
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          smp   <= sample;
          col_r <= column_count;
        end
      end
      ST_SETUP: begin
        if (start_r && auto_en) begin
          div_a <= NW'(run_sum);
          div_b <= FP_D;
        end else begin
          div_a <= prod;
          div_b <= DW'(cur_scale);
        end
      end
      ST_AVG: begin
        if (div_done) begin
          div_a <= NW'(avg_v);
          div_b <= DW'(step_eff);
        end
      end
      ST_AVG_RND: begin
        if (div_done) begin
          rnd_avg <= rnd_cur;
          div_a   <= NW'(pk_v);
          div_b   <= DW'(step_eff);
        end
      end
      ST_PK_RND: begin
        if (div_done) begin
          div_a <= prod;
          div_b <= DW'(fs);
        end
      end
      ST_HEIGHT: begin
        if (div_done) begin
          hgt <= h_clamp;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          column      <= col_r;
          plot_height <= hgt;
          frame_start <= start_r;
          full_scale  <= cur_scale;
        end
      end
      default: ;
    endcase
  end

endmodule

[src/arp_checker.sv]
// port-level checks for the auto-ranging sample plot scaler, with bind
module arp_checker #(
  parameter int FRAME_POINTS = arp_pkg::FRAME_POINTS_DEF,
  parameter int PLOT_HEIGHT  = arp_pkg::PLOT_HEIGHT_DEF,
  localparam int CW = $clog2(FRAME_POINTS),
  localparam int HW = $clog2(PLOT_HEIGHT + 1)
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [CW-1:0]                column,
  input logic [HW-1:0]                plot_height,
  input logic                         frame_start,
  input logic [arp_pkg::SAMPLE_W-1:0] full_scale
);

  import arp_pkg::*;

  localparam logic [HW-1:0] PH_H = HW'(PLOT_HEIGHT);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(column) && $stable(plot_height)
      && $stable(frame_start) && $stable(full_scale))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before item finished");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> plot_height <= PH_H && full_scale != '0)
    else $error("result item out of range");

  a_frame_column: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_start |-> column == '0)
    else $error("frame start away from first column");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind auto_ranging_sample_plot_scaler arp_checker #(
  .FRAME_POINTS(FRAME_POINTS),
  .PLOT_HEIGHT (PLOT_HEIGHT)
) u_arp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .column     (column),
  .plot_height(plot_height),
  .frame_start(frame_start),
  .full_scale (full_scale)
);

[tb/arp_checker.sv]
`timescale 1ns / 100ps
// checker for the plot scaler: predicts each result from accepted samples and compares
module arp_tb_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [arp_pkg::SAMPLE_W-1:0]   sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [6:0]                     column,
  input  logic [7:0]                     plot_height,
  input  logic                           frame_start,
  input  logic [arp_pkg::SAMPLE_W-1:0]   full_scale,
  input  logic                           cfg_write,
  input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             frame_starts
);

  import arp_pkg::*;

  typedef struct packed {
    logic [6:0]          column;
    logic [7:0]          plot_height;
    logic                frame_start;
    logic [SAMPLE_W-1:0] full_scale;
  } plot_point_t;

  plot_point_t expected_points[$];

  logic                cfg_auto;
  logic [SAMPLE_W-1:0] cfg_step;
  int unsigned         col_pos;
  int unsigned         sum_acc;
  int unsigned         peak_acc;
  int unsigned         scale_now;
  bit                  opened;
  int                  fail_cnt;
  int                  start_cnt;

  function automatic int unsigned snap_scale(input int unsigned v, input int unsigned step);
    if (v > SCALE_MAX) v = SCALE_MAX;
    return (v / step) * step;
  endfunction

  function automatic plot_point_t plot_sample(input logic [SAMPLE_W-1:0] s);
    plot_point_t p;
    int unsigned step;
    int unsigned avg2;
    int unsigned pk;
    int unsigned h;
    sum_acc += s;
    if (s > peak_acc) peak_acc = s;
    p.column = col_pos[6:0];
    p.frame_start = 1'b0;
    // the opening sample still counts toward the closing frame
    if (opened && col_pos == 0) begin
      p.frame_start = 1'b1;
      if (cfg_auto) begin
        step = (cfg_step == 0) ? 1 : cfg_step;
        avg2 = snap_scale(2 * (sum_acc / FRAME_POINTS_DEF), step);
        pk = snap_scale((3 * peak_acc) / 2, step);
        scale_now = (avg2 > pk) ? avg2 : pk;
        if (scale_now == 0) scale_now = step;
      end
      sum_acc = 0;
      peak_acc = 0;
    end
    h = (s * PLOT_HEIGHT_DEF) / scale_now;
    if (h > PLOT_HEIGHT_DEF) h = PLOT_HEIGHT_DEF;
    p.plot_height = h[7:0];
    p.full_scale = scale_now[SAMPLE_W-1:0];
    col_pos = (col_pos + 1 >= FRAME_POINTS_DEF) ? 0 : col_pos + 1;
    opened = 1'b1;
    return p;
  endfunction

  always @(posedge clk) begin
    plot_point_t want;
    if (rst) begin
      cfg_auto = AUTO_RST;
      cfg_step = STEP_RST;
      scale_now = SCALE_RST;
      col_pos = 0;
      sum_acc = 0;
      peak_acc = 0;
      opened = 1'b0;
      expected_points.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_AUTO: cfg_auto = cfg_data[0];
          REG_STEP: cfg_step = cfg_data;
          REG_MANUAL: scale_now = (cfg_data == 0) ? 1 : cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_start === 1'b1) start_cnt++;
        if (expected_points.size() == 0) begin
          $error("result with no item waiting: column %0d full_scale %0d", column, full_scale);
          fail_cnt++;
        end else begin
          want = expected_points.pop_front();
          if (column !== want.column) begin
            $error("column: expected %0d, actual %0d", want.column, column);
            fail_cnt++;
          end
          if (plot_height !== want.plot_height) begin
            $error("plot_height: expected %0d, actual %0d", want.plot_height, plot_height);
            fail_cnt++;
          end
          if (frame_start !== want.frame_start) begin
            $error("frame_start: expected %0d, actual %0d", want.frame_start, frame_start);
            fail_cnt++;
          end
          if (full_scale !== want.full_scale) begin
            $error("full_scale: expected %0d, actual %0d", want.full_scale, full_scale);
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) expected_points.push_back(plot_sample(sample));
    end
    pending <= expected_points.size();
    errors <= fail_cnt;
    frame_starts <= start_cnt;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// testbench top for the plot scaler: stimulus, register settings and verdict
module tb;
  import arp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_SETTING = 192;
  localparam int SETTLE_CYCLES = 100;
  localparam int NUM_SETTINGS = 8;

  typedef enum int {WIDE, QUIET, FLAT_ZERO, SPIKY, NEAR_TOP, ONE_BIT} frame_shape_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [6:0]            column;
  logic [7:0]            plot_height;
  logic                  frame_start;
  logic [SAMPLE_W-1:0]   full_scale;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;
  int                    frame_starts;

  int                    send_idle = 15;
  int                    recv_idle = 59;
  int unsigned           cycles = 0;
  int                    items_sent = 0;
  frame_shape_t          shape = WIDE;

  auto_ranging_sample_plot_scaler dut (.*);
  arp_tb_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input frame_shape_t s);
    case (s)
      QUIET: return SAMPLE_W'($urandom_range(63));
      FLAT_ZERO: return '0;
      SPIKY: return ($urandom_range(30) == 0) ? SAMPLE_W'($urandom_range(4095))
                                              : SAMPLE_W'($urandom_range(1500));
      NEAR_TOP: return SAMPLE_W'($urandom_range(4095, 3800));
      ONE_BIT: return 12'd1 << $urandom_range(11);
      default: return SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] directed_samples[12];
    logic                auto_set[NUM_SETTINGS];
    logic [SAMPLE_W-1:0] step_set[NUM_SETTINGS];
    logic [SAMPLE_W-1:0] manual_set[NUM_SETTINGS];
    directed_samples = '{12'd0, 12'd4095, 12'd1, 12'hAAA, 12'h555, 12'd100,
                         12'd99, 12'd101, 12'd4094, 12'd2047, 12'd2048, 12'd70};
    auto_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    step_set = '{12'd1, 12'd4095, 12'd7, 12'd0, 12'd20, SAMPLE_W'($urandom_range(4095, 1)),
                 12'd20, SAMPLE_W'($urandom_range(300, 1))};
    manual_set = '{12'd4095, 12'd1, 12'd0, 12'd37, 12'd4095,
                   SAMPLE_W'($urandom_range(4095, 1)), 12'd100,
                   SAMPLE_W'($urandom_range(4095, 1))};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset
    foreach (directed_samples[i]) push_sample(directed_samples[i]);

    for (int k = 0; k < NUM_SETTINGS; k++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (k < 3) begin
        send_idle = 15;
        recv_idle = 59;
      end else if (k < 6) begin
        send_idle = 59;
        recv_idle = 15;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // upper data bits of the enable register are don't-care
      write_reg(REG_AUTO, {11'($urandom_range(2047)), auto_set[k]});
      write_reg(REG_STEP, step_set[k]);
      if (k == NUM_SETTINGS - 1) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(4095)));
      write_reg(REG_MANUAL, manual_set[k]);
      cfg_write <= 1'b0;
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (items_sent % FRAME_POINTS_DEF == 0) shape = frame_shape_t'($urandom_range(5));
        if ($urandom_range(199) == 0) drain();
        push_sample(pick_sample(shape));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d samples over %0d register settings, %0d frame starts seen",
             items_sent, NUM_SETTINGS + 1, frame_starts);
    $display("step and manual scale taken to 0, 1 and 4095, auto-ranging on and off");
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
src/arp_pkg.sv
src/arp_div.sv
src/auto_ranging_sample_plot_scaler.sv
src/arp_checker.sv
tb/arp_checker.sv
tb/tb.sv
